// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/tpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpq_pkg
// Constants, register indexes and shared types of the quadratic delay map.
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int FRAC_BITS_DEF = 8;

    // Pipeline shape: front stages, then one stage per quotient bit
    localparam int PRE_STAGES = 8;
    localparam int DIV_STAGES = 32;
    localparam int NUM_STAGES = PRE_STAGES + DIV_STAGES;

    // Divisor width: 2 * |a| * |b| * |c| with 17-bit magnitudes
    localparam int DEN_W = 52;

    // Register indexes
    localparam logic [2:0] CFG_TEMP_LOW     = 3'd0;
    localparam logic [2:0] CFG_TEMP_HIGH    = 3'd1;
    localparam logic [2:0] CFG_OXYGEN_LOW   = 3'd2;
    localparam logic [2:0] CFG_OXYGEN_HIGH  = 3'd3;
    localparam logic [2:0] CFG_ACIDITY_LOW  = 3'd4;
    localparam logic [2:0] CFG_ACIDITY_HIGH = 3'd5;

    // Channel constants: node scale and peak delay
    localparam int TEMP_SCALE    = 90;
    localparam int OXYGEN_SCALE  = 20;
    localparam int ACIDITY_SCALE = 8;
    localparam int HEATER_PEAK   = 20000;
    localparam int AERATOR_PEAK  = 540000;
    localparam int DOSING_PEAK   = 20000;

    // Flags that follow a word down the pipeline
    typedef struct packed {
        logic sat;
        logic zero;
        logic fault;
    } tag_t;

endpackage

// ===== sv/tpq_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpq_pipe_ctrl
// Valid bits and per-stage load enables of the shared pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpq_pipe_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tpq_pkg::NUM_STAGES-1:0]  en
);

    localparam int NS = tpq_pkg::NUM_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;

    // A stage loads when it is empty or its word moves on
    always_comb
    begin
        en[NS-1] = ~valid_reg[NS-1] | out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = ~valid_reg[i] | en[i+1];
        end
    end

    // Advance valid bits with the data
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < NS; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];

    `ASSERT_IMPL(a_empty_out_ready, !valid_reg[NS-1], in_ready)
    `ASSERT_NEXT(a_accept_fills, in_valid && in_ready, valid_reg[0])

endmodule

// ===== sv/tpq_div_pipe.sv =====
// ----------------------------------------------------------------------------
// tpq_div_pipe
// Restoring divider, one quotient bit per stage, most significant first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpq_div_pipe (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tpq_pkg::DIV_STAGES-1:0]  en,
    input  logic                            last_valid,
    input  logic [tpq_pkg::DEN_W+31:0]      rem_in,
    input  tpq_pkg::tag_t                   tag_in,
    input  logic [tpq_pkg::DEN_W-1:0]       den,
    output logic [31:0]                     quot,
    output tpq_pkg::tag_t                   tag_out
);

    localparam int DS = tpq_pkg::DIV_STAGES;
    localparam int QW = tpq_pkg::DEN_W + 32;

    logic [QW-1:0]      rem_reg  [DS];
    logic [31:0]        q_reg    [DS];
    tpq_pkg::tag_t      tag_reg  [DS];

    genvar j;
    generate
        for (j = 0; j < DS; j++)
        begin : g_stage
            logic [QW-1:0] rem_prev;
            logic [31:0]   q_prev;
            tpq_pkg::tag_t tag_prev;
            logic [QW-1:0] dsh;
            logic [QW-1:0] rem_next;
            logic [31:0]   q_next;

            if (j == 0)
            begin : g_first
                assign rem_prev = rem_in;
                assign q_prev   = '0;
                assign tag_prev = tag_in;
            end
            else
            begin : g_rest
                assign rem_prev = rem_reg[j-1];
                assign q_prev   = q_reg[j-1];
                assign tag_prev = tag_reg[j-1];
            end

            // Subtract the divisor shifted to this bit when it fits
            always_comb
            begin
                dsh = {den, 32'b0} >> (j + 1);
                if (rem_prev >= dsh)
                begin
                    rem_next = rem_prev - dsh;
                    q_next   = {q_prev[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_prev;
                    q_next   = {q_prev[30:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    rem_reg[j] <= rem_next;
                    q_reg[j]   <= q_next;
                    tag_reg[j] <= tag_prev;
                end
            end
        end
    endgenerate

    assign quot    = q_reg[DS-1];
    assign tag_out = tag_reg[DS-1];

    `ASSERT_IMPL(a_rem_below_den,
        last_valid && !tag_reg[DS-1].sat && !tag_reg[DS-1].zero,
        rem_reg[DS-1] < QW'(den))

endmodule

// ===== sv/tpq_channel.sv =====
// ----------------------------------------------------------------------------
// tpq_channel
// One delay channel: node offsets, Lagrange numerator, scaling and divide.
// ----------------------------------------------------------------------------
module tpq_channel #(
    parameter int FRAC_BITS = tpq_pkg::FRAC_BITS_DEF,
    parameter int M         = 1,
    parameter int PEAK      = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tpq_pkg::NUM_STAGES-1:0]  en,
    input  logic                            last_valid,
    input  logic signed [16:0]              t,
    input  logic signed [15:0]              k1,
    input  logic signed [15:0]              k2,
    input  logic signed [15:0]              k3,
    output logic [31:0]                     delay,
    output logic                            fault
);

    localparam int PS = tpq_pkg::PRE_STAGES;
    localparam int UW = FRAC_BITS + 25;
    localparam int CW = 17;
    localparam int IW = CW + UW + 2;
    localparam int HW = (UW + 1) / 2;
    localparam int PW = IW + UW;
    localparam int NW = PW + 20;
    localparam int RW = NW - 2 * FRAC_BITS;
    localparam int DW = tpq_pkg::DEN_W;
    localparam int QW = DW + 32;
    localparam logic signed [UW-1:0] M_S = UW'(M);
    localparam logic [19:0]          PEAK_U = 20'(PEAK);

    // Node differences; keeping them fixed while words are in flight is left to the user
    logic signed [CW-1:0] a, b, c;
    logic [CW-1:0]        ma, mb, mc;
    logic                 flt;

    always_comb
    begin
        a   = CW'(k1) - CW'(k2);
        b   = CW'(k1) - CW'(k3);
        c   = CW'(k2) - CW'(k3);
        ma  = a[CW-1] ? CW'(-a) : CW'(a);
        mb  = b[CW-1] ? CW'(-b) : CW'(b);
        mc  = c[CW-1] ? CW'(-c) : CW'(c);
        flt = (a == '0) || (b == '0) || (c == '0);
    end

    // Divisor 2|a||b||c|, refreshed every cycle from the thresholds
    logic [2*CW-1:0] ab_reg;
    logic [DW-1:0]   den_reg;

    always_ff @(posedge clk)
    begin
        ab_reg  <= ma * mb;
        den_reg <= {(DW-1)'(ab_reg) * (DW-1)'(mc), 1'b0};
    end

    // Stage 0: hold forecast
    logic signed [16:0] t_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t_reg <= t;
        end
    end

    // Stage 1: offsets from the nodes, u = M*t - k*2^F
    logic signed [UW-1:0] t_ext, mt;
    logic signed [UW-1:0] u1_next, u2_next, u3_next;
    logic signed [UW-1:0] u1_reg, u2_reg, u3_reg;

    always_comb
    begin
        t_ext   = UW'(t_reg);
        mt      = M_S * t_ext;
        u1_next = mt - {{(UW-16-FRAC_BITS){k1[15]}}, k1, {FRAC_BITS{1'b0}}};
        u2_next = mt - {{(UW-16-FRAC_BITS){k2[15]}}, k2, {FRAC_BITS{1'b0}}};
        u3_next = mt - {{(UW-16-FRAC_BITS){k3[15]}}, k3, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            u1_reg <= u1_next;
            u2_reg <= u2_next;
            u3_reg <= u3_next;
        end
    end

    // Stage 2: the two products of the inner term
    logic signed [IW-1:0] p1_next, p2_next, p1_reg, p2_reg;
    logic signed [UW-1:0] u3_s2_reg;

    always_comb
    begin
        p1_next = (IW'(c) * IW'(u2_reg)) <<< 1;
        p2_next = IW'(b) * IW'(u1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            u3_s2_reg <= u3_reg;
        end
    end

    // Stage 3: inner term, sign and magnitudes
    logic signed [IW-1:0] inner;
    logic                 neg;
    logic [IW-1:0]        mi_reg;
    logic [UW-1:0]        mu_reg;
    tpq_pkg::tag_t        tag3_reg;

    always_comb
    begin
        inner = p1_reg - p2_reg;
        neg   = inner[IW-1] ^ u3_s2_reg[UW-1] ^ a[CW-1] ^ b[CW-1] ^ c[CW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            mi_reg         <= inner[IW-1] ? IW'(-inner) : IW'(inner);
            mu_reg         <= u3_s2_reg[UW-1] ? UW'(-u3_s2_reg) : UW'(u3_s2_reg);
            tag3_reg.sat   <= 1'b0;
            tag3_reg.zero  <= neg | flt;
            tag3_reg.fault <= flt;
        end
    end

    // Stage 4: low half of |inner| * |u3|
    logic [PW-1:0]    plo_reg;
    logic [IW-1:0]    mi4_reg;
    logic [UW-HW-1:0] mhi_reg;
    tpq_pkg::tag_t    tag4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            plo_reg  <= PW'(mi_reg) * PW'(mu_reg[HW-1:0]);
            mi4_reg  <= mi_reg;
            mhi_reg  <= mu_reg[UW-1:HW];
            tag4_reg <= tag3_reg;
        end
    end

    // Stage 5: add the high half
    logic [PW-1:0] prod_reg;
    tpq_pkg::tag_t tag5_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            prod_reg <= plo_reg + ((PW'(mi4_reg) * PW'(mhi_reg)) << HW);
            tag5_reg <= tag4_reg;
        end
    end

    // Stage 6: scale by the peak delay
    logic [NW-1:0] num_reg;
    tpq_pkg::tag_t tag6_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            num_reg  <= NW'(prod_reg) * NW'(PEAK_U);
            tag6_reg <= tag5_reg;
        end
    end

    // Stage 7: drop the 2^2F factor of the divisor, check for overflow
    logic [RW-1:0] nums;
    logic [QW-1:0] rem0_reg;
    tpq_pkg::tag_t tag7_reg;

    assign nums = num_reg[NW-1:2*FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (en[PS-1])
        begin
            rem0_reg       <= nums[QW-1:0];
            tag7_reg.sat   <= nums >= RW'({den_reg, 32'b0});
            tag7_reg.zero  <= tag6_reg.zero;
            tag7_reg.fault <= tag6_reg.fault;
        end
    end

    // Quotient bits
    logic [31:0]   quot;
    tpq_pkg::tag_t tag_out;

    tpq_div_pipe u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en[tpq_pkg::NUM_STAGES-1:PS]),
        .last_valid (last_valid),
        .rem_in     (rem0_reg),
        .tag_in     (tag7_reg),
        .den        (den_reg),
        .quot       (quot),
        .tag_out    (tag_out)
    );

    // Saturate and force zero
    always_comb
    begin
        if (tag_out.zero)
        begin
            delay = '0;
        end
        else if (tag_out.sat)
        begin
            delay = '1;
        end
        else
        begin
            delay = quot;
        end
    end

    assign fault = tag_out.fault;

endmodule

// ===== sv/three_point_quadratic_delay_map.sv =====
// ----------------------------------------------------------------------------
// three_point_quadratic_delay_map
// Maps one forecast word to heater, aerator and dosing delays in ms.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     in_valid / in_ready       temperature_q8, oxygen_q8, acidity_q8
// output    out_valid / out_ready     heater/aerator/dosing_delay_ms, node_fault
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One word enters per cycle while in_ready is high; each result passes through
// the 8 front stages and then the 32 quotient-bit stages of the divider.
// Each stage holds only while the one after it is full and stalled, so
// bubbles close up; a waiting result blocks new words only once all 40
// stages are full.
// Reset clears valid bits and loads the default thresholds; cfg_ready is high.
// ----------------------------------------------------------------------------
module three_point_quadratic_delay_map #(
    parameter int FRAC_BITS = tpq_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] temperature_q8,
    input  logic [14:0]        oxygen_q8,
    input  logic [11:0]        acidity_q8,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        heater_delay_ms,
    output logic [31:0]        aerator_delay_ms,
    output logic [31:0]        dosing_delay_ms,
    output logic [2:0]         node_fault,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int NS = tpq_pkg::NUM_STAGES;

    logic signed [7:0] temp_low_reg, temp_high_reg;
    logic [6:0]        oxygen_low_reg, oxygen_high_reg;
    logic [3:0]        acidity_low_reg, acidity_high_reg;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes drop the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_low_reg     <= 8'sd17;
            temp_high_reg    <= 8'sd33;
            oxygen_low_reg   <= 7'd10;
            oxygen_high_reg  <= 7'd40;
            acidity_low_reg  <= 4'd5;
            acidity_high_reg <= 4'd8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tpq_pkg::CFG_TEMP_LOW:     temp_low_reg     <= cfg_data;
                tpq_pkg::CFG_TEMP_HIGH:    temp_high_reg    <= cfg_data;
                tpq_pkg::CFG_OXYGEN_LOW:   oxygen_low_reg   <= cfg_data[6:0];
                tpq_pkg::CFG_OXYGEN_HIGH:  oxygen_high_reg  <= cfg_data[6:0];
                tpq_pkg::CFG_ACIDITY_LOW:  acidity_low_reg  <= cfg_data[3:0];
                tpq_pkg::CFG_ACIDITY_HIGH: acidity_high_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Node numerators, all nodes scaled to a common denominator per channel
    logic signed [15:0] tl, th, ol, oh, al, ah;
    logic signed [15:0] tk1, tk2, tk3, ok1, ok2, ok3, ak1, ak2, ak3;

    always_comb
    begin
        tl  = 16'(temp_low_reg);
        th  = 16'(temp_high_reg);
        ol  = {9'b0, oxygen_low_reg};
        oh  = {9'b0, oxygen_high_reg};
        al  = {12'b0, acidity_low_reg};
        ah  = {12'b0, acidity_high_reg};
        tk1 = 16'sd70 * tl;
        tk2 = 16'sd72 * tl + 16'sd18 * th;
        tk3 = 16'sd45 * tl + 16'sd45 * th;
        ok1 = 16'sd20 * ol;
        ok2 = 16'sd12 * ol + 16'sd8 * oh;
        ok3 = 16'sd5 * ol + 16'sd15 * oh;
        ak1 = 16'sd8 * al;
        ak2 = 16'sd7 * al + ah;
        ak3 = 16'sd6 * al + 16'sd2 * ah;
    end

    logic [NS-1:0] en;

    tpq_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .en        (en)
    );

    tpq_channel #(
        .FRAC_BITS (FRAC_BITS),
        .M         (tpq_pkg::TEMP_SCALE),
        .PEAK      (tpq_pkg::HEATER_PEAK)
    ) u_heater (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .last_valid (out_valid),
        .t          ({temperature_q8[15], temperature_q8}),
        .k1         (tk1),
        .k2         (tk2),
        .k3         (tk3),
        .delay      (heater_delay_ms),
        .fault      (node_fault[0])
    );

    tpq_channel #(
        .FRAC_BITS (FRAC_BITS),
        .M         (tpq_pkg::OXYGEN_SCALE),
        .PEAK      (tpq_pkg::AERATOR_PEAK)
    ) u_aerator (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .last_valid (out_valid),
        .t          ({2'b0, oxygen_q8}),
        .k1         (ok1),
        .k2         (ok2),
        .k3         (ok3),
        .delay      (aerator_delay_ms),
        .fault      (node_fault[1])
    );

    tpq_channel #(
        .FRAC_BITS (FRAC_BITS),
        .M         (tpq_pkg::ACIDITY_SCALE),
        .PEAK      (tpq_pkg::DOSING_PEAK)
    ) u_dosing (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .last_valid (out_valid),
        .t          ({5'b0, acidity_q8}),
        .k1         (ak1),
        .k2         (ak2),
        .k3         (ak3),
        .delay      (dosing_delay_ms),
        .fault      (node_fault[2])
    );

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-point quadratic delay map. A driver feeds
// forecast words from a queue, a monitor compares each result word with a
// delay predicted by exact wide-integer Lagrange evaluation, under several
// threshold settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SCALE_SHIFT  = 8;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [14:0]        oxygen;
        logic [11:0]        acidity;
    } forecast_t;

    typedef struct packed {
        logic [31:0] heater;
        logic [31:0] aerator;
        logic [31:0] dosing;
        logic [2:0]  fault;
    } delays_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] temperature_q8 = '0;
    logic [14:0] oxygen_q8 = '0;
    logic [11:0] acidity_q8 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] heater_delay_ms, aerator_delay_ms, dosing_delay_ms;
    logic [2:0] node_fault;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = tpq_pkg::CFG_TEMP_LOW;
    logic [7:0] cfg_data = '0;

    forecast_t forecast_queue[$];
    delays_t   delay_queue[$];
    logic [7:0] thresholds[6];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    three_point_quadratic_delay_map dut (.*);

    // Clock and one reset at the start
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Delay of one channel: nodes are k/m, the forecast is t/2^8
    function automatic logic [31:0] lagrange_delay(longint m, longint t, longint k1,
            longint k2, longint k3, longint peak, output logic fault);
        longint a, b, c, u1, u2, u3, inner, s;
        longint mi, mu, ma, mb, mc;
        logic [127:0] num, den, q;
        fault = 1'b0;
        a = k1 - k2;
        b = k1 - k3;
        c = k2 - k3;
        s = 64'sd1 <<< SCALE_SHIFT;
        if (a == 0 || b == 0 || c == 0)
        begin
            fault = 1'b1;
            return 32'd0;
        end
        u1 = m * t - s * k1;
        u2 = m * t - s * k2;
        u3 = m * t - s * k3;
        inner = 2 * c * u2 - b * u1;
        if (inner == 0 || u3 == 0)
            return 32'd0;
        if ((inner < 0) ^ (u3 < 0) ^ (a < 0) ^ (b < 0) ^ (c < 0))
            return 32'd0;
        // Work on magnitudes so that every widening is a plain zero fill
        mi = (inner < 0) ? -inner : inner;
        mu = (u3 < 0) ? -u3 : u3;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        mc = (c < 0) ? -c : c;
        num = 128'(mi);
        num = num * 128'(mu);
        num = num * 128'(peak);
        den = 128'(2 * ma);
        den = den * 128'(mb);
        den = den * 128'(mc);
        den = den * 128'(s) * 128'(s);
        q = num / den;
        if (q > 128'hFFFF_FFFF)
            return 32'hFFFF_FFFF;
        return q[31:0];
    endfunction

    function automatic delays_t predict_delays(forecast_t f);
        delays_t d;
        longint tl, th, ol, oh, al, ah;
        logic f0, f1, f2;
        tl = $signed(thresholds[tpq_pkg::CFG_TEMP_LOW]);
        th = $signed(thresholds[tpq_pkg::CFG_TEMP_HIGH]);
        ol = thresholds[tpq_pkg::CFG_OXYGEN_LOW];
        oh = thresholds[tpq_pkg::CFG_OXYGEN_HIGH];
        al = thresholds[tpq_pkg::CFG_ACIDITY_LOW];
        ah = thresholds[tpq_pkg::CFG_ACIDITY_HIGH];
        d.heater = lagrange_delay(tpq_pkg::TEMP_SCALE, longint'(f.temperature), 70 * tl,
            72 * tl + 18 * th, 45 * tl + 45 * th, tpq_pkg::HEATER_PEAK, f0);
        d.aerator = lagrange_delay(tpq_pkg::OXYGEN_SCALE, longint'(f.oxygen), 20 * ol,
            12 * ol + 8 * oh, 5 * ol + 15 * oh, tpq_pkg::AERATOR_PEAK, f1);
        d.dosing = lagrange_delay(tpq_pkg::ACIDITY_SCALE, longint'(f.acidity), 8 * al,
            7 * al + ah, 6 * al + 2 * ah, tpq_pkg::DOSING_PEAK, f2);
        d.fault = {f2, f1, f0};
        return d;
    endfunction

    // Driver: advance to the next word once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                delay_queue.push_back(predict_delays({temperature_q8, oxygen_q8, acidity_q8}));
            if (forecast_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                {temperature_q8, oxygen_q8, acidity_q8} <= forecast_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each result word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        delays_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (delay_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: %0d %0d %0d fault %b",
                            heater_delay_ms, aerator_delay_ms, dosing_delay_ms, node_fault);
                end
                else
                begin
                    want = delay_queue.pop_front();
                    if (want.heater !== heater_delay_ms || want.aerator !== aerator_delay_ms
                        || want.dosing !== dosing_delay_ms || want.fault !== node_fault)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected %0d %0d %0d fault %b, ",
                                "got %0d %0d %0d fault %b"},
                                want.heater, want.aerator, want.dosing, want.fault,
                                heater_delay_ms, aerator_delay_ms, dosing_delay_ms, node_fault);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Register write; valid stays up across back-to-back writes
    task automatic write_threshold(logic [2:0] idx, logic [7:0] value);
        int w[6] = '{8, 8, 7, 7, 4, 4};
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx < 6)
            thresholds[idx] = value & 8'((9'd1 << w[idx]) - 9'd1);
    endtask

    task automatic load_thresholds(logic [7:0] tl, logic [7:0] th, logic [7:0] ol,
            logic [7:0] oh, logic [7:0] al, logic [7:0] ah);
        write_threshold(tpq_pkg::CFG_TEMP_LOW, tl);
        write_threshold(tpq_pkg::CFG_TEMP_HIGH, th);
        write_threshold(tpq_pkg::CFG_OXYGEN_LOW, ol);
        write_threshold(tpq_pkg::CFG_OXYGEN_HIGH, oh);
        write_threshold(tpq_pkg::CFG_ACIDITY_LOW, al);
        write_threshold(tpq_pkg::CFG_ACIDITY_HIGH, ah);
        write_threshold($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
            8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    // Hold until every word has gone and every result has come, then drain
    task automatic wait_idle();
        while (forecast_queue.size() > 0 || in_valid || delay_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_forecast(int t, int o, int p);
        forecast_t f;
        f.temperature = 16'(t);
        f.oxygen = 15'(o);
        f.acidity = 12'(p);
        forecast_queue.push_back(f);
    endtask

    task automatic push_random(int n);
        int t, o, p;
        repeat (n)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                t = $urandom_range(0, 16'hFFFF);
                o = $urandom_range(0, 15'h7FFF);
                p = $urandom_range(0, 12'hFFF);
            end
            else
            begin
                t = int'($urandom_range(0, 32000)) - 10240;
                o = $urandom_range(0, 25600);
                p = $urandom_range(0, 3584);
            end
            push_forecast(t, o, p);
        end
    endtask

    initial
    begin
        int unsigned idle_mode[4][2] = '{'{0, 0}, '{55, 0}, '{0, 55}, '{38, 38}};
        thresholds = '{8'd17, 8'd33, 8'd10, 8'd40, 8'd5, 8'd8};
        @(posedge rst_n);
        @(posedge clk);

        // Directed words at reset thresholds: extremes and node hits
        push_forecast(0, 0, 0);
        push_forecast(16'h7FFF, 15'h7FFF, 12'hFFF);
        push_forecast(-32768, 0, 12'hFFF);
        push_forecast(-10240, 25600, 3584);
        push_forecast(21760, 1, 1);
        push_forecast(25 * 256, 10 * 256, 5 * 256);
        push_forecast(17 * 256, 40 * 256, 8 * 256);
        push_forecast(3 * 256, 7680, 5 * 256 + 96);
        push_forecast(20 * 256 + 51, 22 * 256, 6 * 256 + 192);
        push_forecast(16'h5555, 15'h2AAA, 12'hAAA);
        push_forecast(16'hAAAA, 15'h5555, 12'h555);
        push_forecast(-1, 15'h4000, 12'h800);
        wait_idle();

        // Extreme and coinciding thresholds first, then random ones
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: load_thresholds(-8'sd40, 8'd85, 8'd0, 8'd100, 8'd0, 8'd14);
                1: load_thresholds(8'd127, 8'h80, 8'd127, 8'd0, 8'd15, 8'd0);
                2: load_thresholds(8'd0, 8'd0, 8'd50, 8'd50, 8'd7, 8'd7);
                3: load_thresholds(8'd17, 8'd33, 8'd10, 8'd40, 8'd5, 8'd8);
                4: load_thresholds(8'd5, 8'd5, 8'd200, 8'd255, 8'd255, 8'd240);
                default: load_thresholds(8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
            endcase
            for (int m = 0; m < 4; m++)
            begin
                send_idle_pct = idle_mode[m][0];
                recv_stall_pct = idle_mode[m][1];
                push_random(52);
                while (forecast_queue.size() > 0)
                    @(posedge clk);
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
